// ----- rtl/slm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_pkg
// Types, constants and helpers shared by the substring match locator.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int PatternBytes = 16;
   localparam int PatIdxBits   = $clog2(PatternBytes);
   localparam int LenBits      = 5;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 64;
   localparam int ResultBits   = 32;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_FIND_LAST      = 3'd3,
      CSR_FOLD_CASE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PatternBytes*8-1:0] pattern;
      logic [LenBits-1:0]        length;
      logic                      fold_case;
   } cell_cfg_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
      logic [7:0] r;
      r = c;
      if (en && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/slm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// slm_cell
// One window position: holds a byte, hands it to the next cell on each beat,
// and compares the byte it sees against its pattern byte.
// ----------------------------------------------------------------------------
module slm_cell #(
   parameter int Idx = 0
) (
   input  wire logic                 clock,
   input  wire logic                 shift_en,
   input  wire logic [7:0]           win_byte,
   input  wire slm_pkg::cell_cfg_type cfg,
   output logic [7:0]                byte_out,
   output logic                      ok
);
   import slm_pkg::*;

   logic [7:0]         byte_ff;
   logic [7:0]         byte_in;
   logic               active;
   logic [LenBits-1:0] pat_idx;
   logic [7:0]         pat_byte;

   assign byte_in = win_byte;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // pattern byte aligned with this position: length - 1 - Idx
   assign active  = 32'(cfg.length) > 32'(Idx);
   assign pat_idx = cfg.length - LenBits'(1) - LenBits'(Idx);

   always_comb begin
      pat_byte = '0;
      if (32'(pat_idx) < 32'(PatternBytes)) begin
         pat_byte = cfg.pattern[{pat_idx[PatIdxBits-1:0], 3'b000} +: 8];
      end
   end

   assign ok = !active ||
      (fold_byte(win_byte, cfg.fold_case) == fold_byte(pat_byte, cfg.fold_case));

endmodule
`default_nettype wire

// ----- rtl/substring_match_locator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// substring_match_locator
// Scans a byte stream for a pattern of up to 16 bytes through a chain of
// compare cells; reports first or last occurrence on the final byte.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req_    | in  | tdata[7:0] data_byte, tlast last_byte
//  rsp_    | out | tdata[0] found, tdata[32:1] match_offset (padded to 40)
//  csr_    | in  | we, index, wdata (64 bits), no read-back
//
//  One byte per cycle while req_tready is high; all window positions compare in the same cycle.
//  The result of a final byte is on rsp_ the cycle after it is taken.
//  Single output register: req_tready drops only while a result is held.
//  Synchronous reset clears configuration, counters and the output valid.
// ----------------------------------------------------------------------------
module substring_match_locator #(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [39:0]                            rsp_tdata,   // [0] found, [32:1] offset
   input  wire logic                              csr_we,
   input  wire logic [slm_pkg::CsrIndexBits-1:0]  csr_index,
   input  wire logic [slm_pkg::CsrDataBits-1:0]   csr_wdata
);
   import slm_pkg::*;

   localparam int ExtBits = (OFFSET_BITS > ResultBits) ? OFFSET_BITS : ResultBits;
   localparam logic [OFFSET_BITS-1:0] SeenMax = '1;

   logic [PatternBytes*8-1:0] pattern_ff;
   logic [LenBits-1:0]        length_ff;
   logic                      find_last_ff;
   logic                      fold_case_ff;

   logic [OFFSET_BITS-1:0]    seen_ff, seen_in;
   logic                      hit_ff, hit_in;
   logic [OFFSET_BITS-1:0]    hit_off_ff, hit_off_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [ResultBits-1:0]     rsp_offset_ff, rsp_offset_in;

   logic                      req_acc;
   cell_cfg_type              cell_cfg;
   logic [7:0]                win [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]    cell_ok;
   logic [OFFSET_BITS-1:0]    seen_next;
   logic [OFFSET_BITS-1:0]    len_ext;
   logic                      len_fits;
   logic                      match;
   logic                      hit_next;
   logic [OFFSET_BITS-1:0]    hit_off_next;
   logic [ExtBits-1:0]        off_ext;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= '0;
         find_last_ff <= 1'b0;
         fold_case_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pattern_ff[63:0]   <= csr_wdata;
            CSR_PATTERN_HIGH:   pattern_ff[127:64] <= csr_wdata;
            CSR_PATTERN_LENGTH: length_ff          <= csr_wdata[LenBits-1:0];
            CSR_FIND_LAST:      find_last_ff       <= csr_wdata[0];
            CSR_FOLD_CASE:      fold_case_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cell_cfg.pattern   = pattern_ff;
   assign cell_cfg.length    = length_ff;
   assign cell_cfg.fold_case = fold_case_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   // window chain: cell i sees the i-th newest byte including this beat
   assign win[0] = req_tdata;

   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
      if (i < PATTERN_MAX - 1) begin : g_mid
         slm_cell #(.Idx(i)) u_cell (
            .clock    (clock),
            .shift_en (req_acc),
            .win_byte (win[i]),
            .cfg      (cell_cfg),
            .byte_out (win[i+1]),
            .ok       (cell_ok[i])
         );
      end else begin : g_end
         slm_cell #(.Idx(i)) u_cell (
            .clock    (clock),
            .shift_en (req_acc),
            .win_byte (win[i]),
            .cfg      (cell_cfg),
            .byte_out (),
            .ok       (cell_ok[i])
         );
      end
   end

   // occurrence tracking
   assign seen_next = (seen_ff == SeenMax) ? seen_ff : seen_ff + OFFSET_BITS'(1);
   assign len_ext   = OFFSET_BITS'(length_ff);
   assign len_fits  = (length_ff != '0) && (32'(length_ff) <= 32'(PATTERN_MAX));
   assign match     = len_fits && (seen_next >= len_ext) && (&cell_ok);

   always_comb begin
      hit_next     = hit_ff;
      hit_off_next = hit_off_ff;
      if (match && (find_last_ff || !hit_ff)) begin
         hit_next     = 1'b1;
         hit_off_next = seen_next - len_ext;
      end
   end

   always_comb begin
      seen_in    = seen_ff;
      hit_in     = hit_ff;
      hit_off_in = hit_off_ff;
      if (req_acc) begin
         if (req_tlast) begin
            seen_in    = '0;
            hit_in     = 1'b0;
            hit_off_in = '0;
         end else begin
            seen_in    = seen_next;
            hit_in     = hit_next;
            hit_off_in = hit_off_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         hit_ff     <= 1'b0;
         hit_off_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         hit_ff     <= hit_in;
         hit_off_ff <= hit_off_in;
      end
   end

   // result register
   always_comb begin
      off_ext = '0;
      if (length_ff == '0) begin
         if (find_last_ff) begin
            off_ext = ExtBits'(seen_next);
         end
      end else if (hit_next) begin
         off_ext = ExtBits'(hit_off_next);
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (req_acc && req_tlast) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = (length_ff == '0) || hit_next;
         rsp_offset_in = off_ext[ResultBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_offset_ff, rsp_found_ff};

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> rsp_tvalid)
      else $error("final beat produced no result");

   a_plain_beat_no_result: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_tlast && !rsp_valid_ff |=> !rsp_tvalid)
      else $error("result without final beat");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> seen_ff == '0 && !hit_ff)
      else $error("stream state not cleared after final beat");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_tlast && seen_ff != SeenMax
      |=> seen_ff == OFFSET_BITS'($past(seen_ff) + OFFSET_BITS'(1)))
      else $error("byte count did not advance");

   a_offset_idle: assert property (@(posedge clock) disable iff (reset)
      !hit_ff |-> hit_off_ff == '0)
      else $error("offset held without a hit");

endmodule
`default_nettype wire

// ----- test/tb_substring_match_locator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_match_locator
// Streams byte buffers through the locator and checks each found flag and
// offset against an in-bench scanner. A short table of hand-picked buffers
// and register writes comes first. Randomized phases follow, each with its
// own pattern, search direction, case folding and backpressure profile.
// ----------------------------------------------------------------------------
module tb_substring_match_locator;
   import slm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 5;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_BYTES    = 40;
   localparam int PLAN_ROWS      = 25;

   typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type idx;
      logic [63:0]   value;
      logic [7:0]    data;
      logic          last;
      logic          typed;
      logic          found;
      logic [31:0]   offset;
   } plan_row_type;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } search_outcome_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = 8'h00;   // [7:0] data_byte
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;           // [0] found, [32:1] match_offset
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_PATTERN_LOW;
   logic [63:0]   csr_wdata = 64'd0;

   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int idle_cycles   = 0;

   // scanner state and register copy
   logic [127:0] pat_bytes = '0;
   logic [4:0]   pat_len   = '0;
   logic         want_last = 1'b0;
   logic         fold_on   = 1'b0;
   logic [7:0]   window [16];
   logic [31:0]  seen_count = '0;
   logic         hit_flag   = 1'b0;
   logic [31:0]  hit_pos    = '0;

   logic               typed_beat = 1'b0;
   search_outcome_type typed_outcome = '0;
   search_outcome_type pending_outcomes [$];

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_WRITE, CSR_FIND_LAST,      64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h41, 1'b1, 1'b1, 1'b1, 32'd3},
      '{ROW_WRITE, CSR_PATTERN_LOW,    64'h6241, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_FIND_LAST,      64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_FOLD_CASE,      64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h62, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h7A, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_FOLD_CASE,      64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_FIND_LAST,      64'd1, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h41, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h42, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h41, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'h62, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0,
        32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd31, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_BYTE,  CSR_PATTERN_LOW,    64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0}
   };

   substring_match_locator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [7:0] fold_letter(input logic [7:0] c);
      if (fold_on && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] noise_byte();
      logic [7:0] picks [8];
      picks = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h41, 8'h5A, 8'h61, 8'h7A};
      case ($urandom_range(3))
         0: return 8'($urandom_range(255));
         1: return pat_bytes[8*$urandom_range(15) +: 8];
         2: return 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
         default: return picks[$urandom_range(7)];
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic l);
      int len;
      int k;
      logic matched;
      search_outcome_type outcome;
      len = pat_len;
      for (k = 15; k > 0; k--) begin
         window[k] = window[k-1];
      end
      window[0] = b;
      if (seen_count != 32'hFFFF_FFFF) begin
         seen_count++;
      end
      if (len > 0 && len <= 16 && seen_count >= len) begin
         matched = 1'b1;
         for (k = 0; k < len; k++) begin
            if (fold_letter(window[len-1-k]) != fold_letter(pat_bytes[8*k +: 8])) begin
               matched = 1'b0;
            end
         end
         if (matched && (want_last || !hit_flag)) begin
            hit_flag = 1'b1;
            hit_pos  = seen_count - 32'(len);
         end
      end
      if (l) begin
         if (len == 0) begin
            outcome = '{1'b1, want_last ? seen_count : 32'd0};
         end else if (hit_flag) begin
            outcome = '{1'b1, hit_pos};
         end else begin
            outcome = '{1'b0, 32'd0};
         end
         pending_outcomes.push_back(typed_beat ? typed_outcome : outcome);
         foreach (window[k]) window[k] = 8'h00;
         seen_count = '0;
         hit_flag   = 1'b0;
         hit_pos    = '0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result with none pending", rsp_tdata[31:0], 32'd0);
            end else begin
               if (rsp_tdata[0] !== pending_outcomes[0].found) begin
                  report_mismatch("found", 32'(rsp_tdata[0]), 32'(pending_outcomes[0].found));
               end
               if (rsp_tdata[32:1] !== pending_outcomes[0].offset) begin
                  report_mismatch("match_offset", rsp_tdata[32:1], pending_outcomes[0].offset);
               end
               void'(pending_outcomes.pop_front());
            end
         end
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tlast);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                            input logic found, input logic [31:0] offset);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      typed_beat    = typed;
      typed_outcome = '{found, offset};
      req_tdata     = b;
      req_tlast     = l;
      req_tvalid    = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW:    pat_bytes[63:0]   = value;
         CSR_PATTERN_HIGH:   pat_bytes[127:64] = value;
         CSR_PATTERN_LENGTH: pat_len           = value[4:0];
         CSR_FIND_LAST:      want_last         = value[0];
         CSR_FOLD_CASE:      fold_on           = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure_phase(input int phase);
      logic [127:0] p;
      int length;
      logic lastsel;
      logic foldsel;
      int k;
      for (k = 0; k < 16; k++) begin
         if ($urandom_range(3) == 0) begin
            p[8*k +: 8] = 8'($urandom_range(255));
         end else begin
            p[8*k +: 8] = 8'($urandom_range(8'h61, 8'h7A)) ^ ($urandom_range(1) ? 8'h20 : 8'h00);
         end
      end
      length  = $urandom_range(1, 16);
      lastsel = 1'($urandom_range(1));
      foldsel = 1'($urandom_range(1));
      case (phase)
         0: begin
            p = '1; length = 16; lastsel = 1'b0; foldsel = 1'b0;
         end
         2: begin
            length = 1; lastsel = 1'b0; foldsel = 1'b0;
         end
         3: begin
            length = 0; lastsel = 1'b1;
         end
         4: begin
            p = '0; length = 16; lastsel = 1'b1; foldsel = 1'b1;
         end
         default: ;
      endcase
      write_csr(CSR_PATTERN_LOW, p[63:0]);
      write_csr(CSR_PATTERN_HIGH, p[127:64]);
      write_csr(CSR_PATTERN_LENGTH, 64'(length));
      write_csr(CSR_FIND_LAST, 64'(lastsel));
      write_csr(CSR_FOLD_CASE, 64'(foldsel));
   endtask

   initial begin
      int r;
      int phase;
      int sent;
      int blen;
      int n;
      int cut;
      int k;
      logic [7:0] c;
      foreach (window[k]) window[k] = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (r = 0; r < PLAN_ROWS; r++) begin
         if (directed_plan[r].kind == ROW_WRITE) begin
            wait_drained();
            write_csr(directed_plan[r].idx, directed_plan[r].value);
         end else begin
            send_byte(directed_plan[r].data, directed_plan[r].last, directed_plan[r].typed,
                      directed_plan[r].found, directed_plan[r].offset);
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_gap_pct = 8; rsp_stall_pct = 8; end
         endcase
         configure_phase(phase);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            blen = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            n = 0;
            while (n < blen) begin
               if (pat_len > 0 && pat_len <= 16 && $urandom_range(99) < 35) begin
                  // splice in a copy of the pattern, sometimes cut short
                  cut = ($urandom_range(3) == 0) ? $urandom_range(1, pat_len) : int'(pat_len);
                  for (k = 0; k < cut && n < blen; k++) begin
                     c = pat_bytes[8*k +: 8];
                     if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A
                         && $urandom_range(3) == 0) begin
                        c = c ^ 8'h20;
                     end
                     send_byte(c, n == blen - 1, 1'b0, 1'b0, 32'd0);
                     n++;
                  end
               end else begin
                  send_byte(noise_byte(), n == blen - 1, 1'b0, 1'b0, 32'd0);
                  n++;
               end
            end
            sent += blen;
            if ($urandom_range(19) == 0) begin
               wait_drained();
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- substring_match_locator.f -----
rtl/slm_pkg.sv
rtl/slm_cell.sv
rtl/substring_match_locator.sv
test/tb_substring_match_locator.sv
